### rtl/frw_pkg.sv
// ----------------------------------------------------------------------------
// frw_pkg
// Shared types, constants and helpers for the FM redundant write filter.
// ----------------------------------------------------------------------------
package frw_pkg;

	// Shadow geometry
	localparam int REG_COUNT = 512;
	localparam int ADDR_W    = $clog2(REG_COUNT);
	localparam int ENTRY_W   = 9;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	// Register map constants
	localparam addr_t  KEYON_ADDR    = 9'h028;
	localparam logic [7:0] KEYON_DATA_MASK = 8'hF0;
	localparam logic [3:0] FREQ_BLOCK = 4'hA;
	localparam addr_t  LATCH_BASE    = 9'h010;
	localparam addr_t  PAIR_BIT      = 9'h004;
	localparam entry_t STEREO_RESET  = 9'h0C0;
	localparam entry_t ENTRY_UNKNOWN = 9'h1FF;

	// Operation codes of an input beat
	typedef enum logic [1:0] {
		OP_LEARN  = 2'd0,
		OP_LOOP   = 2'd1,
		OP_FILTER = 2'd2
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMP,
		ST_LAT,
		ST_RES,
		ST_LOOP,
		ST_DRAIN
	} state_t;

	// One access slot of a shadow RAM
	typedef struct packed {
		logic   re;
		addr_t  ra;
		logic   we;
		addr_t  wa;
		entry_t wd;
	} ram_req_t;

	// Result handed from the controller to the output register
	typedef struct packed {
		logic valid;
		logic keep;
	} res_t;

	// Power-up content of a shadow entry: stereo/pan registers hold 0xC0
	function automatic entry_t reset_value(input addr_t a);
		entry_t v;
		v = '0;
		if (a[7:0] == 8'hB0 || a[7:0] == 8'hB1 || a[7:0] == 8'hB2) begin
			v = STEREO_RESET;
		end
		return v;
	endfunction

endpackage

### rtl/frw_ram.sv
// ----------------------------------------------------------------------------
// frw_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module frw_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

### rtl/frw_ctrl.sv
// ----------------------------------------------------------------------------
// frw_ctrl
// Sequencer for the filter: clearing pass, read-modify-write of shadow
// entries, frequency latch handling and the loop-point sweep.
// ----------------------------------------------------------------------------
module frw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [8:0]        address,
	input  logic [7:0]        value,
	input  logic              safe_mode,
	input  logic              out_free,
	output frw_pkg::res_t     res,
	output frw_pkg::ram_req_t live_req,
	output frw_pkg::ram_req_t final_req,
	input  frw_pkg::entry_t   live_rd,
	input  frw_pkg::entry_t   final_rd
);

	import frw_pkg::*;

	state_t   state_q, state_d;
	addr_t    idx_q;          // clear / sweep index
	addr_t    idx_s1;         // sweep entry whose read data is back
	logic     v_s1;
	logic     sel_live_q;     // target shadow of the current write
	logic     filt_q;         // current beat returns a result
	logic     freq_q;         // frequency block write
	logic     second_q;       // low-byte write may still need the latch copy
	addr_t    addr_q;
	addr_t    ent_q;
	entry_t   dat_q;
	logic     keep_q;

	// accept-cycle decode
	logic     accept;
	logic     freq_in;
	addr_t    ent_in;
	entry_t   dat_in;
	logic     second_in;

	// compare stage
	entry_t   old_rd;
	logic     chg;
	logic     keep_now;
	addr_t    latch_addr;
	ram_req_t req;

	assign accept     = in_valid && in_ready;
	assign freq_in    = (address[7:4] == FREQ_BLOCK);
	assign old_rd     = sel_live_q ? live_rd : final_rd;
	assign chg        = (old_rd != dat_q) || dat_q[ENTRY_W-1];
	assign keep_now   = chg || (freq_q && safe_mode);
	assign latch_addr = LATCH_BASE | {6'd0, addr_q[2], 2'b00};

	// entry and data of the first store
	always_comb begin
		ent_in    = address;
		dat_in    = {1'b0, value};
		second_in = 1'b0;
		if (freq_in && address[3]) begin
			ent_in = LATCH_BASE | {6'd0, address[2], 2'b00};
		end else if (freq_in) begin
			second_in = 1'b1;
		end else if (address == KEYON_ADDR) begin
			ent_in = {6'd0, value[2:0]};
			dat_in = {1'b0, value & KEYON_DATA_MASK};
		end
	end

	// next state and memory requests
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res       = '0;
		req       = '0;
		live_req  = '0;
		final_req = '0;
		unique case (state_q)
			ST_CLEAR: begin
				live_req.we  = 1'b1;
				live_req.wa  = idx_q;
				live_req.wd  = reset_value(idx_q);
				final_req.we = 1'b1;
				final_req.wa = idx_q;
				final_req.wd = reset_value(idx_q);
				if (idx_q == addr_t'(REG_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (operation)
						OP_LEARN: begin
							final_req.re = 1'b1;
							final_req.ra = ent_in;
							state_d      = ST_CMP;
						end
						OP_FILTER: begin
							live_req.re = 1'b1;
							live_req.ra = ent_in;
							state_d     = ST_CMP;
						end
						OP_LOOP: begin
							state_d = ST_LOOP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CMP: begin
				req.we = 1'b1;
				req.wa = ent_q;
				req.wd = dat_q;
				if (second_q && !chg) begin
					// unchanged low byte: fetch the latch for the paired entry
					req.re  = 1'b1;
					req.ra  = latch_addr;
					state_d = ST_LAT;
				end else if (filt_q) begin
					res.valid = out_free;
					res.keep  = keep_now;
					state_d   = out_free ? ST_IDLE : ST_RES;
				end else begin
					state_d = ST_IDLE;
				end
				if (sel_live_q) begin
					live_req = req;
				end else begin
					final_req = req;
				end
			end
			ST_LAT: begin
				req.re  = 1'b1;
				req.ra  = addr_q | PAIR_BIT;
				state_d = ST_CMP;
				if (sel_live_q) begin
					live_req = req;
				end else begin
					final_req = req;
				end
			end
			ST_RES: begin
				res.valid = out_free;
				res.keep  = keep_q;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOOP, ST_DRAIN: begin
				if (state_q == ST_LOOP) begin
					live_req.re  = 1'b1;
					live_req.ra  = idx_q;
					final_req.re = 1'b1;
					final_req.ra = idx_q;
					if (idx_q == addr_t'(REG_COUNT - 1)) begin
						state_d = ST_DRAIN;
					end
				end else begin
					state_d = ST_IDLE;
				end
				// mark entries that differ from the final shadow as unknown
				if (v_s1 && (live_rd != final_rd)) begin
					live_req.we = 1'b1;
					live_req.wa = idx_s1;
					live_req.wd = ENTRY_UNKNOWN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_LOOP);
			if (state_q == ST_CLEAR || state_q == ST_LOOP) begin
				idx_q <= idx_q + addr_t'(1);
			end
		end
	end

	// beat context and datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			sel_live_q <= (operation == OP_FILTER);
			filt_q     <= (operation == OP_FILTER);
			freq_q     <= freq_in;
			second_q   <= second_in;
			addr_q     <= address;
			ent_q      <= ent_in;
			dat_q      <= dat_in;
		end else if (state_q == ST_CMP) begin
			second_q <= 1'b0;
			keep_q   <= keep_now;
		end else if (state_q == ST_LAT) begin
			ent_q <= addr_q | PAIR_BIT;
			dat_q <= old_rd;
		end
	end

endmodule

### rtl/fm_redundant_write_filter.sv
// ----------------------------------------------------------------------------
// fm_redundant_write_filter
// Drops FM register writes that leave the chip state unchanged.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 512 entries of both
// shadows and holds in_ready low until it ends. An ordinary learning or
// filtered write is accepted with a shadow read, then compared and written
// back; an unchanged low-byte frequency write then passes ST_LAT and a
// second compare, since the latch entry and then the paired entry are read
// through the same RAM read port. A loop point sweeps all 512 entries one
// per cycle, then drains. One item is worked on at a time; a filtered write
// waits at its end only while the output register holds an untaken result.
module fm_redundant_write_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [8:0] address,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       keep,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);

	import frw_pkg::*;

	logic     safe_mode_q;
	logic     out_vld_q;
	logic     keep_q;
	logic     out_free;
	res_t     res;
	ram_req_t live_req, final_req;
	entry_t   live_rd, final_rd;

	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign keep      = keep_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			safe_mode_q <= cfg_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.valid) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			keep_q <= res.keep;
		end
	end

	// sequencer
	frw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.address   (address),
		.value     (value),
		.safe_mode (safe_mode_q),
		.out_free  (out_free),
		.res       (res),
		.live_req  (live_req),
		.final_req (final_req),
		.live_rd   (live_rd),
		.final_rd  (final_rd)
	);

	// live shadow
	frw_ram #(.DEPTH(REG_COUNT), .WIDTH(ENTRY_W)) u_live_ram (
		.clk (clk),
		.re  (live_req.re),
		.ra  (live_req.ra),
		.rd  (live_rd),
		.we  (live_req.we),
		.wa  (live_req.wa),
		.wd  (live_req.wd)
	);

	// final shadow
	frw_ram #(.DEPTH(REG_COUNT), .WIDTH(ENTRY_W)) u_final_ram (
		.clk (clk),
		.re  (final_req.re),
		.ra  (final_req.ra),
		.rd  (final_rd),
		.we  (final_req.we),
		.wa  (final_req.wa),
		.wd  (final_req.wd)
	);

`ifndef SYNTHESIS
	// a result is only pushed when the output register can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!out_vld_q || out_ready))
		else $error("result pushed into a full output register");

	// no read of an entry in the cycle it is written
	a_live_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(live_req.re && live_req.we && (live_req.ra == live_req.wa)))
		else $error("live shadow read and write collide");

	a_final_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(final_req.re && final_req.we && (final_req.ra == final_req.wa)))
		else $error("final shadow read and write collide");

	// a filtered write ends in a single result, so results never come in consecutive cycles
	a_res_one: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> !res.valid)
		else $error("two results in consecutive cycles");
`endif

endmodule
